@@ src/distance_vector_table_update_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the distance-vector table update unit
// Implication forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_UNIT_ASSERT_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define DVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvt assertion failed");

// next-cycle implication
`define DVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvt assertion failed");

`endif

@@ src/dvt_pkg.sv @@
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared constants, codes and types of the distance-vector table update unit.
// ----------------------------------------------------------------------------
package dvt_pkg;

    localparam int NODES_DEFAULT     = 16;
    localparam int COST_BITS_DEFAULT = 16;
    localparam int NODE_W            = 4;
    localparam int CMD_W             = 2;
    localparam int STATUS_W          = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADVERT = 2'd0,
        CMD_LOCAL  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CHANGED  = 2'd0,
        ST_NOCHANGE = 2'd1,
        ST_REJECT   = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

endpackage

@@ src/dvt_table.sv @@
// ----------------------------------------------------------------------------
// dvt_table
// Route table memory: cost and next hop per node, two registered read ports,
// one write port; per-entry valid flags make unwritten entries read no route.
// ----------------------------------------------------------------------------
module dvt_table
#(
    parameter int NODES     = 16,
    parameter int COST_BITS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_a_idx,
    input  logic [IDX_W-1:0]         rd_b_idx,
    output logic [COST_BITS-1:0]     rd_a_cost,
    output logic [COST_BITS-1:0]     rd_b_cost,
    output logic [dvt_pkg::NODE_W-1:0] rd_b_hop,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_idx,
    input  logic [COST_BITS-1:0]     wr_cost,
    input  logic [dvt_pkg::NODE_W-1:0] wr_hop
);
    import dvt_pkg::*;

    localparam int ENTRY_W = COST_BITS + NODE_W;

    logic [ENTRY_W-1:0] mem_reg [NODES];
    logic [NODES-1:0]   valid_reg;
    logic [ENTRY_W-1:0] rd_a_reg;
    logic [ENTRY_W-1:0] rd_b_reg;
    logic               rd_a_valid_reg;
    logic               rd_b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= {wr_cost, wr_hop};
        end
        if (rd_en)
        begin
            rd_a_reg <= mem_reg[rd_a_idx];
            rd_b_reg <= mem_reg[rd_b_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_a_valid_reg <= 1'b0;
            rd_b_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_a_valid_reg <= valid_reg[rd_a_idx];
                rd_b_valid_reg <= valid_reg[rd_b_idx];
            end
        end
    end

    assign rd_a_cost = rd_a_valid_reg ? rd_a_reg[ENTRY_W-1:NODE_W] : '1;
    assign rd_b_cost = rd_b_valid_reg ? rd_b_reg[ENTRY_W-1:NODE_W] : '1;
    assign rd_b_hop  = rd_b_valid_reg ? rd_b_reg[NODE_W-1:0] : '0;

endmodule

@@ src/dvt_engine.sv @@
// ----------------------------------------------------------------------------
// dvt_engine
// Command sequencer: issues table reads on accept, applies the update rule,
// writes the entry back when it changes and loads the result register.
// ----------------------------------------------------------------------------
module dvt_engine
#(
    parameter int NODES     = 16,
    parameter int COST_BITS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dvt_pkg::NODE_W-1:0]    my_node,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dvt_pkg::CMD_W-1:0]     cmd,
    input  logic [dvt_pkg::NODE_W-1:0]    from_node,
    input  logic [dvt_pkg::NODE_W-1:0]    to_node,
    input  logic [COST_BITS-1:0]          cost,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dvt_pkg::STATUS_W-1:0]  status,
    output logic [COST_BITS-1:0]          dest_cost,
    output logic [dvt_pkg::NODE_W-1:0]    dest_next_hop,
    output logic                          update_pending,
    output logic                          rd_en,
    output logic [IDX_W-1:0]              rd_a_idx,
    output logic [IDX_W-1:0]              rd_b_idx,
    input  logic [COST_BITS-1:0]          rd_a_cost,
    input  logic [COST_BITS-1:0]          rd_b_cost,
    input  logic [dvt_pkg::NODE_W-1:0]    rd_b_hop,
    output logic                          wr_en,
    output logic [IDX_W-1:0]              wr_idx,
    output logic [COST_BITS-1:0]          wr_cost,
    output logic [dvt_pkg::NODE_W-1:0]    wr_hop
);
    import dvt_pkg::*;

    localparam logic [COST_BITS-1:0] NO_ROUTE = '1;
    localparam logic [COST_BITS-1:0] COST_MAX = {1'b0, {(COST_BITS-1){1'b1}}};

    state_t              state_reg;
    state_t              state_next;
    cmd_t                cmd_reg;
    logic [NODE_W-1:0]   src_reg;
    logic [NODE_W-1:0]   dst_reg;
    logic [COST_BITS-1:0] cost_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    logic [COST_BITS-1:0] dest_cost_reg;
    logic [NODE_W-1:0]   dest_hop_reg;
    logic                out_pending_reg;
    logic                pending_reg;
    logic                pending_next;

    logic                accept;
    logic                finish;

    logic                src_ok;
    logic                dst_ok;
    logic [COST_BITS-1:0] cost_c;
    logic [COST_BITS:0]  sum;
    logic [COST_BITS-1:0] total;
    status_t             status_c;
    logic                upd_c;
    logic [COST_BITS-1:0] new_cost_c;
    logic [NODE_W-1:0]   new_hop_c;
    logic [COST_BITS-1:0] rep_cost_c;
    logic [NODE_W-1:0]   rep_hop_c;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready = 1'b0;
        finish   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_CALC:
            begin
                finish = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept   = in_valid && in_ready;
    assign rd_en    = accept;
    assign rd_a_idx = IDX_W'(from_node);
    assign rd_b_idx = IDX_W'(to_node);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(cmd);
            src_reg  <= from_node;
            dst_reg  <= to_node;
            cost_reg <= cost;
        end
    end

    // update rule
    assign src_ok = 32'(src_reg) < NODES;
    assign dst_ok = 32'(dst_reg) < NODES;
    assign cost_c = cost_reg[COST_BITS-1] ? NO_ROUTE : cost_reg;
    assign sum    = {1'b0, cost_c} + {1'b0, rd_a_cost};
    assign total  = sum[COST_BITS-1] ? COST_MAX : sum[COST_BITS-1:0];

    always_comb
    begin
        status_c   = ST_NOCHANGE;
        upd_c      = 1'b0;
        new_cost_c = rd_b_cost;
        new_hop_c  = rd_b_hop;
        case (cmd_reg)
            CMD_ADVERT:
            begin
                if (!src_ok || !dst_ok || src_reg == my_node)
                begin
                    status_c = ST_REJECT;
                end
                else if (dst_reg != src_reg && dst_reg != my_node &&
                         !cost_c[COST_BITS-1] && !rd_a_cost[COST_BITS-1])
                begin
                    if (rd_b_cost[COST_BITS-1] || rd_b_cost > total)
                    begin
                        upd_c      = 1'b1;
                        new_cost_c = total;
                        new_hop_c  = src_reg;
                    end
                    else if (rd_b_hop == src_reg && rd_b_cost < total)
                    begin
                        upd_c      = 1'b1;
                        new_cost_c = total;
                    end
                end
            end
            CMD_LOCAL:
            begin
                if (!dst_ok || src_reg != my_node)
                begin
                    status_c = ST_REJECT;
                end
                else if (dst_reg != my_node)
                begin
                    if (rd_b_cost != cost_c || rd_b_hop != dst_reg)
                    begin
                        upd_c      = 1'b1;
                        new_cost_c = cost_c;
                        new_hop_c  = dst_reg;
                    end
                end
            end
            default:
            begin
                if (!dst_ok)
                begin
                    status_c = ST_REJECT;
                end
            end
        endcase
        if (upd_c)
        begin
            status_c = ST_CHANGED;
        end

        pending_next = ((cmd_reg == CMD_CLEAR) ? 1'b0 : pending_reg) || upd_c;

        if (!dst_ok)
        begin
            rep_cost_c = NO_ROUTE;
            rep_hop_c  = '0;
        end
        else if (dst_reg == my_node)
        begin
            rep_cost_c = '0;
            rep_hop_c  = my_node;
        end
        else
        begin
            rep_cost_c = new_cost_c;
            rep_hop_c  = new_hop_c;
        end
    end

    assign wr_en   = finish && upd_c;
    assign wr_idx  = IDX_W'(dst_reg);
    assign wr_cost = new_cost_c;
    assign wr_hop  = new_hop_c;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                pending_reg <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg      <= status_c;
            dest_cost_reg   <= rep_cost_c;
            dest_hop_reg    <= rep_hop_c;
            out_pending_reg <= pending_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign dest_cost      = dest_cost_reg;
    assign dest_next_hop  = dest_hop_reg;
    assign update_pending = out_pending_reg;

endmodule

@@ src/distance_vector_table_update_unit.sv @@
// ----------------------------------------------------------------------------
// distance_vector_table_update_unit
// Distance-vector routing table: cost and next hop per destination node.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: cmd,
//   from_node, to_node, cost. Output channel (out_valid/out_ready) returns
//   one result item per command: status, dest_cost, dest_next_hop and
//   update_pending, describing the entry for to_node after the command.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes my_node;
//   it is always ready; the user must write it only while the block is idle,
//   which the block itself does not enforce. An accepted item is read
//   through the registered read ports of the route memory, and no new item
//   is taken until the table read-modify-write in the compute step ends.
//   A new item is taken while the previous result still waits; if the
//   receiver stalls, the next item waits in the compute step until the
//   result register frees, and in_ready stays low meanwhile.
//   Reset clears per-entry valid flags at once, so every route reads
//   as no route with next hop 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module distance_vector_table_update_unit
#(
    parameter int NODES     = dvt_pkg::NODES_DEFAULT,
    parameter int COST_BITS = dvt_pkg::COST_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dvt_pkg::NODE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dvt_pkg::CMD_W-1:0]     cmd,
    input  logic [dvt_pkg::NODE_W-1:0]    from_node,
    input  logic [dvt_pkg::NODE_W-1:0]    to_node,
    input  logic [COST_BITS-1:0]          cost,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dvt_pkg::STATUS_W-1:0]  status,
    output logic [COST_BITS-1:0]          dest_cost,
    output logic [dvt_pkg::NODE_W-1:0]    dest_next_hop,
    output logic                          update_pending
);
    import dvt_pkg::*;

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

    logic [NODE_W-1:0]    my_node_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_a_idx;
    logic [IDX_W-1:0]     rd_b_idx;
    logic [COST_BITS-1:0] rd_a_cost;
    logic [COST_BITS-1:0] rd_b_cost;
    logic [NODE_W-1:0]    rd_b_hop;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [COST_BITS-1:0] wr_cost;
    logic [NODE_W-1:0]    wr_hop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_node_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            my_node_reg <= cfg_data;
        end
    end

    dvt_table #(
        .NODES     (NODES),
        .COST_BITS (COST_BITS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_a_idx  (rd_a_idx),
        .rd_b_idx  (rd_b_idx),
        .rd_a_cost (rd_a_cost),
        .rd_b_cost (rd_b_cost),
        .rd_b_hop  (rd_b_hop),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_cost   (wr_cost),
        .wr_hop    (wr_hop)
    );

    dvt_engine #(
        .NODES     (NODES),
        .COST_BITS (COST_BITS),
        .IDX_W     (IDX_W)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .my_node        (my_node_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .from_node      (from_node),
        .to_node        (to_node),
        .cost           (cost),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .dest_cost      (dest_cost),
        .dest_next_hop  (dest_next_hop),
        .update_pending (update_pending),
        .rd_en          (rd_en),
        .rd_a_idx       (rd_a_idx),
        .rd_b_idx       (rd_b_idx),
        .rd_a_cost      (rd_a_cost),
        .rd_b_cost      (rd_b_cost),
        .rd_b_hop       (rd_b_hop),
        .wr_en          (wr_en),
        .wr_idx         (wr_idx),
        .wr_cost        (wr_cost),
        .wr_hop         (wr_hop)
    );

endmodule

@@ src/dvt_checker.sv @@
// ----------------------------------------------------------------------------
// dvt_checker
// Port-level checks of the distance-vector table update unit, bound to it.
// ----------------------------------------------------------------------------
`include "distance_vector_table_update_unit_assert.svh"

module dvt_checker
#(
    parameter int COST_BITS = dvt_pkg::COST_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [dvt_pkg::STATUS_W-1:0]  status,
    input  logic [COST_BITS-1:0]          dest_cost,
    input  logic                          update_pending
);
    import dvt_pkg::*;

    // held result stays put
    `DVT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(dest_cost) && $stable(status))

    `DVT_ASSERT_NOW(a_status_code, clk, rst_n, out_valid,
        status == ST_CHANGED || status == ST_NOCHANGE || status == ST_REJECT)

    `DVT_ASSERT_NOW(a_change_pending, clk, rst_n, out_valid && status == ST_CHANGED,
        update_pending)

    // one item in flight
    `DVT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind distance_vector_table_update_unit dvt_checker #(
    .COST_BITS (COST_BITS)
) u_dvt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .dest_cost      (dest_cost),
    .update_pending (update_pending)
);
